FILE: src/vcg_pkg.sv
`timescale 1ns / 1ps

package vcg_pkg;

   // saturated totals fit in 28 bits (65535*16*255 < 2**28)
   localparam int TOT_W = 28;
   // quotient of a saturated total by 17 or more
   localparam int CTH_W = 24;
   // cylinder-times-heads value that goes on to the cylinder divide
   localparam int SEL_W = 20;
   // x operand of the cylinder divide when heads is not 16
   localparam int CX_W  = 14;
   localparam int CYL_W = 16;
   localparam int HD_W  = 5;
   localparam int SPT_W = 8;
   localparam int RCP_W = 17;
   localparam int RCP_SHIFT = 18;

   localparam logic [TOT_W-1:0] MAX_SECTORS = TOT_W'(65535 * 16 * 255);
   localparam logic [TOT_W-1:0] BIG_SECTORS = TOT_W'(65535 * 16 * 63);

   localparam logic [SPT_W-1:0] SPT_17  = 8'd17;
   localparam logic [SPT_W-1:0] SPT_31  = 8'd31;
   localparam logic [SPT_W-1:0] SPT_63  = 8'd63;
   localparam logic [SPT_W-1:0] SPT_255 = 8'd255;

   localparam logic [HD_W-1:0] MIN_HEADS = 5'd4;
   localparam logic [HD_W-1:0] MAX_HEADS = 5'd16;

   localparam int CTH_PER_HEAD_LOG2 = 10;
   localparam logic [CTH_W-1:0] FB_LIMIT = CTH_W'(16 * 1024);

   typedef struct packed {
      logic [SEL_W-1:0] cth;
      logic [HD_W-1:0]  heads;
      logic [SPT_W-1:0] spt;
   } geo_type;

   // floor(2**18 / heads) for heads 4..15
   function automatic logic [RCP_W-1:0] cyl_recip(input logic [HD_W-1:0] heads);
      logic [RCP_W-1:0] r;
      case (heads)
         5'd4:    r = 17'd65536;
         5'd5:    r = 17'd52428;
         5'd6:    r = 17'd43690;
         5'd7:    r = 17'd37449;
         5'd8:    r = 17'd32768;
         5'd9:    r = 17'd29127;
         5'd10:   r = 17'd26214;
         5'd11:   r = 17'd23831;
         5'd12:   r = 17'd21845;
         5'd13:   r = 17'd20164;
         5'd14:   r = 17'd18724;
         5'd15:   r = 17'd17476;
         default: r = 17'd16384;
      endcase
      return r;
   endfunction

endpackage

FILE: src/vcg_cdiv.sv
`timescale 1ns / 1ps

// two-stage divide of a saturated total by a fixed divisor:
// reciprocal multiply, then one compare-and-increment correction
module vcg_cdiv #(
   parameter int DIVISOR = 17
) (
   input  logic                       clock,
   input  logic [1:0]                 en,
   input  logic [vcg_pkg::TOT_W-1:0]  x,
   output logic [vcg_pkg::CTH_W-1:0]  quot
);

   localparam int PROD_W = 2 * vcg_pkg::TOT_W;
   localparam longint RECIP = (64'd1 << 32) / DIVISOR;
   localparam logic [vcg_pkg::TOT_W-1:0] RECIP_W = vcg_pkg::TOT_W'(RECIP);
   localparam logic [vcg_pkg::TOT_W-1:0] DIV_W   = vcg_pkg::TOT_W'(DIVISOR);

   logic [PROD_W-1:0]          prod;
   logic [vcg_pkg::CTH_W-1:0]  qe_in, qe_ff;
   logic [vcg_pkg::TOT_W-1:0]  x_ff;
   logic [vcg_pkg::TOT_W-1:0]  back;
   logic [vcg_pkg::TOT_W-1:0]  rem;
   logic [vcg_pkg::CTH_W-1:0]  q_in, q_ff;

   // estimate is the true quotient or one below it
   assign prod  = PROD_W'(x) * PROD_W'(RECIP_W);
   assign qe_in = prod[32 +: vcg_pkg::CTH_W];

   assign back = vcg_pkg::TOT_W'(qe_ff) * DIV_W;
   assign rem  = x_ff - back;
   assign q_in = (rem >= DIV_W) ? qe_ff + 1'b1 : qe_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qe_ff <= qe_in;
         x_ff  <= x;
      end
      if (en[1]) begin
         q_ff <= q_in;
      end
   end

   assign quot = q_ff;

endmodule

FILE: src/vcg_select.sv
`timescale 1ns / 1ps

// picks sectors per track, heads and the cylinder-times-heads count
module vcg_select (
   input  logic                       clock,
   input  logic                       en,
   input  logic                       big,
   input  logic [vcg_pkg::CTH_W-1:0]  cth17,
   input  logic [vcg_pkg::CTH_W-1:0]  cth31,
   input  logic [vcg_pkg::CTH_W-1:0]  cth63,
   input  logic [vcg_pkg::CTH_W-1:0]  cth255,
   output vcg_pkg::geo_type           geo
);

   localparam int CW = vcg_pkg::CTH_W + 1;
   localparam int HW = CW - vcg_pkg::CTH_PER_HEAD_LOG2;

   logic [CW-1:0]    round_up;
   logic [HW-1:0]    hc;
   logic [HW-1:0]    h17;
   logic [CW-1:0]    h17_cap;
   logic             fb1;
   logic             fb2;
   vcg_pkg::geo_type geo_in, geo_ff;

   assign round_up = CW'(cth17) + CW'(1023);
   assign hc       = HW'(round_up >> vcg_pkg::CTH_PER_HEAD_LOG2);
   assign h17      = (hc < HW'(vcg_pkg::MIN_HEADS)) ? HW'(vcg_pkg::MIN_HEADS) : hc;
   assign h17_cap  = CW'(h17) << vcg_pkg::CTH_PER_HEAD_LOG2;

   // 17 sectors does not fit, then 31 sectors with 16 heads does not fit
   assign fb1 = (CW'(cth17) >= h17_cap) || (h17 > HW'(vcg_pkg::MAX_HEADS));
   assign fb2 = cth31 >= vcg_pkg::FB_LIMIT;

   always_comb begin
      if (big) begin
         geo_in.spt   = vcg_pkg::SPT_255;
         geo_in.heads = vcg_pkg::MAX_HEADS;
         geo_in.cth   = cth255[vcg_pkg::SEL_W-1:0];
      end else if (!fb1) begin
         geo_in.spt   = vcg_pkg::SPT_17;
         geo_in.heads = h17[vcg_pkg::HD_W-1:0];
         geo_in.cth   = cth17[vcg_pkg::SEL_W-1:0];
      end else if (!fb2) begin
         geo_in.spt   = vcg_pkg::SPT_31;
         geo_in.heads = vcg_pkg::MAX_HEADS;
         geo_in.cth   = cth31[vcg_pkg::SEL_W-1:0];
      end else begin
         geo_in.spt   = vcg_pkg::SPT_63;
         geo_in.heads = vcg_pkg::MAX_HEADS;
         geo_in.cth   = cth63[vcg_pkg::SEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff <= geo_in;
      end
   end

   assign geo = geo_ff;

endmodule

FILE: src/vcg_cyl.sv
`timescale 1ns / 1ps

// cylinders = cth / heads over two stages; 16 heads is a plain shift
module vcg_cyl (
   input  logic                       clock,
   input  logic [1:0]                 en,
   input  vcg_pkg::geo_type           geo,
   output logic [vcg_pkg::CYL_W-1:0]  cylinders,
   output logic [vcg_pkg::HD_W-1:0]   heads,
   output logic [vcg_pkg::SPT_W-1:0]  sectors_per_track
);

   localparam int PW = vcg_pkg::CX_W + vcg_pkg::RCP_W;

   logic                        is16_in, is16_ff;
   logic [PW-1:0]               prod;
   logic [vcg_pkg::CYL_W-1:0]   qa_in, qa_ff;
   logic [vcg_pkg::CX_W-1:0]    xa_ff;
   logic [vcg_pkg::HD_W-1:0]    ha_ff;
   logic [vcg_pkg::SPT_W-1:0]   sa_ff;
   logic [vcg_pkg::CX_W-1:0]    back;
   logic [vcg_pkg::CX_W-1:0]    rem;
   logic [vcg_pkg::CYL_W-1:0]   cyl_in, cyl_ff;
   logic [vcg_pkg::HD_W-1:0]    hb_ff;
   logic [vcg_pkg::SPT_W-1:0]   sb_ff;

   assign is16_in = geo.heads == vcg_pkg::MAX_HEADS;
   // below 16 heads the count stays under heads*1024, so 14 bits suffice
   assign prod = PW'(geo.cth[vcg_pkg::CX_W-1:0]) * PW'(vcg_pkg::cyl_recip(geo.heads));
   assign qa_in = is16_in ? vcg_pkg::CYL_W'(geo.cth >> 4)
                          : vcg_pkg::CYL_W'(prod >> vcg_pkg::RCP_SHIFT);

   assign back   = vcg_pkg::CX_W'(qa_ff[9:0]) * vcg_pkg::CX_W'(ha_ff);
   assign rem    = xa_ff - back;
   assign cyl_in = (!is16_ff && rem >= vcg_pkg::CX_W'(ha_ff)) ? qa_ff + 1'b1 : qa_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         is16_ff <= is16_in;
         qa_ff   <= qa_in;
         xa_ff   <= geo.cth[vcg_pkg::CX_W-1:0];
         ha_ff   <= geo.heads;
         sa_ff   <= geo.spt;
      end
      if (en[1]) begin
         cyl_ff <= cyl_in;
         hb_ff  <= ha_ff;
         sb_ff  <= sa_ff;
      end
   end

   assign cylinders         = cyl_ff;
   assign heads             = hb_ff;
   assign sectors_per_track = sb_ff;

endmodule

FILE: src/vhd_chs_geometry.sv
`timescale 1ns / 1ps

// VHD cylinder/head/sector geometry from a disk size in 512-byte sectors.
// The unit is a six-stage pipeline and takes one item per clock unless
// the output side stalls. After the input register come the
// constant-divisor dividers (reciprocal multiply plus correction, two
// stages), the geometry select stage and the two-stage cylinder divide,
// whose last register is the output register. Each stage holds its own
// valid bit, so bubbles close up under backpressure.
module vhd_chs_geometry (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [47:0]  req_total_sectors,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [15:0]  rsp_cylinders,
   output logic [4:0]   rsp_heads,
   output logic [7:0]   rsp_sectors_per_track
);

   localparam int NSTAGE = 6;

   logic [NSTAGE-1:0]          v_ff;
   logic [NSTAGE-1:0]          en;
   logic [vcg_pkg::TOT_W-1:0]  tot_in, tot_ff;
   logic                       big1_ff, big2_ff;
   logic [vcg_pkg::CTH_W-1:0]  cth17, cth31, cth63, cth255;
   vcg_pkg::geo_type           geo;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en[NSTAGE-1] = !v_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // saturate at 65535*16*255
   assign tot_in = (req_total_sectors > 48'(vcg_pkg::MAX_SECTORS))
                   ? vcg_pkg::MAX_SECTORS : req_total_sectors[vcg_pkg::TOT_W-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tot_ff <= tot_in;
      end
      if (en[1]) begin
         big1_ff <= tot_ff >= vcg_pkg::BIG_SECTORS;
      end
      if (en[2]) begin
         big2_ff <= big1_ff;
      end
   end

   vcg_cdiv #(.DIVISOR(17)) u_div17 (
      .clock (clock), .en (en[2:1]), .x (tot_ff), .quot (cth17)
   );

   vcg_cdiv #(.DIVISOR(31)) u_div31 (
      .clock (clock), .en (en[2:1]), .x (tot_ff), .quot (cth31)
   );

   vcg_cdiv #(.DIVISOR(63)) u_div63 (
      .clock (clock), .en (en[2:1]), .x (tot_ff), .quot (cth63)
   );

   vcg_cdiv #(.DIVISOR(255)) u_div255 (
      .clock (clock), .en (en[2:1]), .x (tot_ff), .quot (cth255)
   );

   vcg_select u_select (
      .clock  (clock),
      .en     (en[3]),
      .big    (big2_ff),
      .cth17  (cth17),
      .cth31  (cth31),
      .cth63  (cth63),
      .cth255 (cth255),
      .geo    (geo)
   );

   vcg_cyl u_cyl (
      .clock             (clock),
      .en                (en[5:4]),
      .geo               (geo),
      .cylinders         (rsp_cylinders),
      .heads             (rsp_heads),
      .sectors_per_track (rsp_sectors_per_track)
   );

   a_heads_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heads >= vcg_pkg::MIN_HEADS && rsp_heads <= vcg_pkg::MAX_HEADS))
      else $error("heads out of range");

   a_spt_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sectors_per_track == vcg_pkg::SPT_17 ||
                     rsp_sectors_per_track == vcg_pkg::SPT_31 ||
                     rsp_sectors_per_track == vcg_pkg::SPT_63 ||
                     rsp_sectors_per_track == vcg_pkg::SPT_255))
      else $error("bad sectors per track");

   a_fallback_heads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sectors_per_track != vcg_pkg::SPT_17)
         |-> rsp_heads == vcg_pkg::MAX_HEADS)
      else $error("fallback geometry without 16 heads");

   a_small_cyl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sectors_per_track == vcg_pkg::SPT_17) |-> rsp_cylinders < 16'd1024)
      else $error("17-sector geometry with too many cylinders");

endmodule
